/* design/bsa_pkg.sv */
// Shared types and constants for the bitmap slot allocator.
// Holds the request/result structs, status codes, sequencer states and the
// find-first-zero helper. Depends on nothing.
`default_nettype none

package bsa_pkg;

	localparam int SLOT_W      = 14;
	localparam int BIT_W       = 6;
	localparam int WORD_W      = 64;
	localparam int SLOT_WORD_W = SLOT_W - BIT_W;
	localparam int ACT_PAGES_W = 5;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} bsa_req_type_t;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_FULL   = 2'd1,
		STATUS_DOUBLE = 2'd2,
		STATUS_RANGE  = 2'd3
	} bsa_status_t;

	typedef struct packed {
		bsa_req_type_t     req_type;
		logic [SLOT_W-1:0] free_slot;
	} bsa_req_t;

	typedef struct packed {
		bsa_status_t       status;
		logic [SLOT_W-1:0] slot;
	} bsa_rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FREE_CHK,
		S_FREE_WR
	} bsa_state_t;

	// Index of the lowest clear bit. The lowest zero is isolated as a one-hot
	// vector with a two's-complement trick and then encoded into a binary index.
	function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] inv;
		logic [WORD_W-1:0] iso;
		logic [BIT_W-1:0]  idx;
		inv = ~w;
		iso = inv & (~inv + WORD_W'(1));
		idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			idx = idx | (iso[i] ? BIT_W'(i) : '0);
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

/* design/bsa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the allocation bitmap. Depends on nothing.
`default_nettype none

module bsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                       wr_data,
	input  wire logic                                   rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* design/bitmap_slot_allocator.sv */
// Top level of the bitmap slot allocator: sequencer, cursor and config.
// Uses bsa_pkg and one bsa_ram instance for the bitmap words.
//
// A request is taken when start is high and busy is low. An allocate reads
// one bitmap word per cycle through the RAM read port, starting at the
// next-fit cursor. A free goes through a read, a check and quotient step,
// and a write back; a double free ends after the check, and a free of an
// out-of-range slot is answered from idle without a RAM access.
// The result is shown for exactly one cycle with done high, in the cycle
// after the last step; it cannot be held off, and busy is already low then.
// After reset the block clears every bitmap word with busy high;
// configuration writes are taken during that time.
`default_nettype none

module bitmap_slot_allocator
	import bsa_pkg::*;
#(
	parameter int PAGE_WORDS = 16,
	parameter int MAX_PAGES  = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire bsa_req_t               req,
	output logic                        busy,
	output logic                        done,
	output bsa_rsp_t                    result,
	input  wire logic                   cfg_wr_en,
	input  wire logic [ACT_PAGES_W-1:0] cfg_wr_data
);

	localparam int TOTAL = PAGE_WORDS * MAX_PAGES;
	localparam int WW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int OW    = (PAGE_WORDS > 1) ? $clog2(PAGE_WORDS) : 1;
	localparam int WAW   = (WW > SLOT_WORD_W) ? WW : SLOT_WORD_W;
	localparam int CMPW  = WAW + 1;
	localparam int PCW_N = $clog2(MAX_PAGES + 1);
	localparam int PCW   = (PCW_N > ACT_PAGES_W) ? PCW_N : ACT_PAGES_W;
	localparam int SW    = WAW + BIT_W;
	localparam logic [WW:0] RECIP = (WW + 1)'((1 << WW) / PAGE_WORDS);

	bsa_state_t          state_q, state_d;
	logic [WW-1:0]       clr_q, clr_d;
	logic [CMPW-1:0]     limit_q;
	logic [WW-1:0]       cursor_q, cursor_d;
	logic [OW-1:0]       coff_q, coff_d;
	logic [WW-1:0]       scan_q, scan_d;
	logic [OW-1:0]       soff_q, soff_d;
	logic [WW-1:0]       base_q, base_d;
	logic [WAW-1:0]      fword_q, fword_d;
	logic [BIT_W-1:0]    fbit_q, fbit_d;
	logic [WW-1:0]       qe_q, qe_d;
	logic                done_q, done_d;
	bsa_rsp_t            result_q, result_d;

	logic                ram_we;
	logic [WW-1:0]       ram_wa;
	logic [WORD_W-1:0]   ram_wd;
	logic                ram_re;
	logic [WW-1:0]       ram_ra;
	logic [WORD_W-1:0]   ram_rd;

	logic [PCW-1:0]      pages_in;
	logic [PCW-1:0]      pages_eff;
	logic [CMPW-1:0]     limit_cfg;

	// Effective page count: zero acts as one, anything above the maximum
	// acts as the maximum.
	always_comb begin
		pages_in = PCW'(cfg_wr_data);
		priority if (pages_in == '0) begin
			pages_eff = PCW'(1);
		end else if (pages_in > PCW'(MAX_PAGES)) begin
			pages_eff = PCW'(MAX_PAGES);
		end else begin
			pages_eff = pages_in;
		end
		limit_cfg = CMPW'(pages_eff * PAGE_WORDS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= CMPW'(PAGE_WORDS);
		end else if (cfg_wr_en) begin
			limit_q <= limit_cfg;
		end
	end

	bsa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TOTAL)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_wa),
		.wr_data(ram_wd),
		.rd_en  (ram_re),
		.rd_addr(ram_ra),
		.rd_data(ram_rd)
	);

	logic                cur_oor;
	logic [WW-1:0]       start_word;
	logic [OW-1:0]       start_off;
	logic [WAW-1:0]      req_word;
	logic [CMPW-1:0]     nxt_w;
	logic [OW:0]         soff_inc;
	logic                page_end;
	logic [WW-1:0]       nxt_word;
	logic [OW-1:0]       nxt_off;
	logic [BIT_W-1:0]    free_bit;
	logic [2*WW:0]       qe_prod;
	logic [WW:0]         rem_raw;
	logic [WW:0]         rem_fix;
	logic [SW-1:0]       slot_wide;

	always_comb begin
		state_d  = state_q;
		clr_d    = clr_q;
		cursor_d = cursor_q;
		coff_d   = coff_q;
		scan_d   = scan_q;
		soff_d   = soff_q;
		base_d   = base_q;
		fword_d  = fword_q;
		fbit_d   = fbit_q;
		qe_d     = qe_q;
		done_d   = 1'b0;
		result_d = result_q;
		ram_we   = 1'b0;
		ram_wa   = scan_q;
		ram_wd   = '0;
		ram_re   = 1'b0;
		ram_ra   = scan_q;

		// A cursor left beyond the active area restarts at word zero.
		cur_oor    = CMPW'(cursor_q) >= limit_q;
		start_word = cur_oor ? '0 : cursor_q;
		start_off  = cur_oor ? '0 : coff_q;
		req_word   = WAW'(req.free_slot[SLOT_W-1:BIT_W]);

		nxt_w    = CMPW'(scan_q) + CMPW'(1);
		soff_inc = (OW + 1)'(soff_q) + (OW + 1)'(1);
		page_end = soff_inc == (OW + 1)'(PAGE_WORDS);
		nxt_word = (page_end && (nxt_w >= limit_q)) ? '0 : nxt_w[WW-1:0];
		nxt_off  = page_end ? '0 : soff_inc[OW-1:0];

		free_bit  = lowest_clear(ram_rd);
		slot_wide = {WAW'(scan_q), free_bit};

		// Quotient estimate by reciprocal; it is exact or one too small.
		qe_prod = (2 * WW + 1)'(fword_q[WW-1:0]) * (2 * WW + 1)'(RECIP);
		rem_raw = (WW + 1)'(fword_q[WW-1:0]) - (WW + 1)'(qe_q * PAGE_WORDS);
		rem_fix = (rem_raw >= (WW + 1)'(PAGE_WORDS)) ?
			rem_raw - (WW + 1)'(PAGE_WORDS) : rem_raw;

		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_wa = clr_q;
				ram_wd = '0;
				clr_d  = clr_q + WW'(1);
				if (clr_q == WW'(TOTAL - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					if (req.req_type == REQ_ALLOC) begin
						scan_d  = start_word;
						soff_d  = start_off;
						base_d  = start_word - WW'(start_off);
						ram_re  = 1'b1;
						ram_ra  = start_word;
						state_d = S_SCAN;
					end else if (CMPW'(req_word) >= limit_q) begin
						done_d   = 1'b1;
						result_d = '{status: STATUS_RANGE, slot: '0};
					end else begin
						fword_d = req_word;
						fbit_d  = req.free_slot[BIT_W-1:0];
						ram_re  = 1'b1;
						ram_ra  = req_word[WW-1:0];
						state_d = S_FREE_CHK;
					end
				end
			end
			S_SCAN: begin
				if (ram_rd != '1) begin
					ram_we   = 1'b1;
					ram_wa   = scan_q;
					ram_wd   = ram_rd | (WORD_W'(1) << free_bit);
					done_d   = 1'b1;
					result_d = '{status: STATUS_OK, slot: slot_wide[SLOT_W-1:0]};
					cursor_d = scan_q;
					coff_d   = soff_q;
					state_d  = S_IDLE;
				end else if (page_end && (nxt_word == base_q)) begin
					// Came back around to the page the scan began in.
					done_d   = 1'b1;
					result_d = '{status: STATUS_FULL, slot: '0};
					cursor_d = nxt_word;
					coff_d   = '0;
					state_d  = S_IDLE;
				end else begin
					scan_d = nxt_word;
					soff_d = nxt_off;
					ram_re = 1'b1;
					ram_ra = nxt_word;
				end
			end
			S_FREE_CHK: begin
				if (!ram_rd[fbit_q]) begin
					done_d   = 1'b1;
					result_d = '{status: STATUS_DOUBLE, slot: '0};
					state_d  = S_IDLE;
				end else begin
					qe_d    = qe_prod[WW +: WW];
					state_d = S_FREE_WR;
				end
			end
			S_FREE_WR: begin
				ram_we   = 1'b1;
				ram_wa   = fword_q[WW-1:0];
				ram_wd   = ram_rd & ~(WORD_W'(1) << fbit_q);
				done_d   = 1'b1;
				result_d = '{status: STATUS_OK, slot: '0};
				if (CMPW'(fword_q) < CMPW'(cursor_q)) begin
					cursor_d = fword_q[WW-1:0];
					coff_d   = rem_fix[OW-1:0];
				end
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			cursor_q <= '0;
			coff_q   <= '0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			clr_q    <= clr_d;
			cursor_q <= cursor_d;
			coff_q   <= coff_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		scan_q   <= scan_d;
		soff_q   <= soff_d;
		base_q   <= base_d;
		fword_q  <= fword_d;
		fbit_q   <= fbit_d;
		qe_q     <= qe_d;
		result_q <= result_d;
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire
